FILE: sv/bmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_pkg - shared definitions for the binary min-heap priority queue
// Sizes, operation and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bmh_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 2;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_LD,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_CHK,
        S_DN_CMP,
        S_FIN
    } bmh_state_t;

    typedef struct packed {
        logic push_start;
        logic push_full;
        logic pop_empty;
        logic pop_start;
        logic pop_load;
        logic up_read;
        logic up_step;
        logic hole_place;
        logic dn_read;
        logic dn_step;
        logic out_load;
    } bmh_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic one_left;
        logic pos_zero;
        logic up_more;
        logic dn_leaf;
        logic dn_more;
    } bmh_stat_t;

endpackage

FILE: sv/bmh_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_dpath - heap datapath
// Key memory (one write, two registered reads), hole register, position and
// count registers, root shadow and the result word registers.
// ----------------------------------------------------------------------------
module bmh_dpath import bmh_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bmh_cmd_t                cmd,
    output bmh_stat_t               stat,
    input  logic signed [KEY_W-1:0] key_in,
    output logic signed [KEY_W-1:0] removed_key,
    output logic signed [KEY_W-1:0] min_key,
    output logic [CNT_W-1:0]        entry_count,
    output logic [1:0]              status
);

    logic signed [KEY_W-1:0] key_mem [CAPACITY];
    logic signed [KEY_W-1:0] rd_a_reg, rd_b_reg;

    logic signed [KEY_W-1:0] hole_reg, hole_next;
    logic signed [KEY_W-1:0] removed_reg, removed_next;
    logic signed [KEY_W-1:0] root_reg;
    logic [1:0]              stat_reg, stat_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0]       pos_reg, pos_next;

    logic signed [KEY_W-1:0] out_removed_reg, out_min_reg;
    logic [CNT_W-1:0]        out_cnt_reg;
    logic [1:0]              out_stat_reg;

    logic [ADDR_W-1:0]       parent;
    logic [IDX_W-1:0]        left_idx, right_idx, cnt_ext;
    logic                    right_ok, left_lt, right_lt;
    logic signed [KEY_W-1:0] best_val;
    logic [ADDR_W-1:0]       rd_a_addr, rd_b_addr;
    logic                    wr_en;
    logic signed [KEY_W-1:0] wr_data;

    assign parent    = ADDR_W'(pos_reg - 1'b1) >> 1;
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + 1'b1;
    assign cnt_ext   = IDX_W'(cnt_reg);
    assign right_ok  = right_idx < cnt_ext;
    assign left_lt   = hole_reg > rd_a_reg;
    assign best_val  = left_lt ? rd_a_reg : hole_reg;
    assign right_lt  = right_ok && (best_val > rd_b_reg);

    assign stat.full     = cnt_reg == CNT_W'(CAPACITY);
    assign stat.empty    = cnt_reg == '0;
    assign stat.one_left = cnt_reg == CNT_W'(1);
    assign stat.pos_zero = pos_reg == '0;
    assign stat.up_more  = rd_a_reg > hole_reg;
    assign stat.dn_leaf  = left_idx >= cnt_ext;
    assign stat.dn_more  = left_lt || right_lt;

    always_comb begin
        rd_a_addr = ADDR_W'(cnt_reg - 1'b1);
        rd_b_addr = right_idx[ADDR_W-1:0];
        if (cmd.up_read) begin
            rd_a_addr = parent;
        end else if (cmd.dn_read) begin
            rd_a_addr = left_idx[ADDR_W-1:0];
        end
    end

    always_comb begin
        hole_next    = hole_reg;
        removed_next = removed_reg;
        stat_next    = stat_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        wr_en        = 1'b0;
        wr_data      = hole_reg;
        if (cmd.push_start) begin
            hole_next    = key_in;
            removed_next = '0;
            stat_next    = ST_OK;
            cnt_next     = cnt_reg + 1'b1;
            pos_next     = cnt_reg[ADDR_W-1:0];
        end
        if (cmd.push_full) begin
            removed_next = '0;
            stat_next    = ST_FULL;
        end
        if (cmd.pop_empty) begin
            removed_next = '0;
            stat_next    = ST_EMPTY;
        end
        if (cmd.pop_start) begin
            removed_next = root_reg;
            stat_next    = ST_OK;
            cnt_next     = cnt_reg - 1'b1;
            pos_next     = '0;
        end
        if (cmd.pop_load) begin
            hole_next = rd_a_reg;
        end
        if (cmd.hole_place) begin
            wr_en = 1'b1;
        end
        if (cmd.up_step) begin
            wr_en = 1'b1;
            if (stat.up_more) begin
                wr_data  = rd_a_reg;
                pos_next = parent;
            end
        end
        if (cmd.dn_step) begin
            wr_en = 1'b1;
            if (right_lt) begin
                wr_data  = rd_b_reg;
                pos_next = right_idx[ADDR_W-1:0];
            end else if (left_lt) begin
                wr_data  = rd_a_reg;
                pos_next = left_idx[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[pos_reg] <= wr_data;
        end
        rd_a_reg <= key_mem[rd_a_addr];
        rd_b_reg <= key_mem[rd_b_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        hole_reg    <= hole_next;
        removed_reg <= removed_next;
        stat_reg    <= stat_next;
        pos_reg     <= pos_next;
        if (wr_en && pos_reg == '0) begin
            root_reg <= wr_data;
        end
        if (cmd.out_load) begin
            out_removed_reg <= removed_reg;
            out_min_reg     <= stat.empty ? '0 : root_reg;
            out_cnt_reg     <= cnt_reg;
            out_stat_reg    <= stat_reg;
        end
    end

    assign removed_key = out_removed_reg;
    assign min_key     = out_min_reg;
    assign entry_count = out_cnt_reg;
    assign status      = out_stat_reg;

endmodule

FILE: sv/bmh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_ctrl - heap controller
// Sequences push sift-up and pop sift-down, a check and a compare state per
// heap level, and owns both handshakes.
// ----------------------------------------------------------------------------
module bmh_ctrl import bmh_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_action,
    output logic      m_valid,
    input  logic      m_ready,
    output bmh_cmd_t  cmd,
    input  bmh_stat_t stat
);

    bmh_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_action == ACT_PUSH) begin
                        if (stat.full) begin
                            cmd.push_full = 1'b1;
                            state_next    = S_FIN;
                        end else begin
                            cmd.push_start = 1'b1;
                            state_next     = S_UP_CHK;
                        end
                    end else begin
                        if (stat.empty) begin
                            cmd.pop_empty = 1'b1;
                            state_next    = S_FIN;
                        end else begin
                            cmd.pop_start = 1'b1;
                            state_next    = stat.one_left ? S_FIN : S_POP_LD;
                        end
                    end
                end
            end
            S_POP_LD: begin
                cmd.pop_load = 1'b1;
                state_next   = S_DN_CHK;
            end
            S_UP_CHK: begin
                if (stat.pos_zero) begin
                    cmd.hole_place = 1'b1;
                    state_next     = S_FIN;
                end else begin
                    cmd.up_read = 1'b1;
                    state_next  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                cmd.up_step = 1'b1;
                state_next  = stat.up_more ? S_UP_CHK : S_FIN;
            end
            S_DN_CHK: begin
                if (stat.dn_leaf) begin
                    cmd.hole_place = 1'b1;
                    state_next     = S_FIN;
                end else begin
                    cmd.dn_read = 1'b1;
                    state_next  = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                cmd.dn_step = 1'b1;
                state_next  = stat.dn_more ? S_DN_CHK : S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: sv/binary_min_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue - min-heap of signed 32-bit keys
// Push or pop-minimum per input word, one result word per input word.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. A push places the key in a hole at
// the end and lets it climb; a pop takes the root and lets the last key sink
// from the root. Each level is a check state and then a compare state, and
// the key is written into the hole where it stops; a pop that empties the
// heap skips the sift. The worst case is a push that climbs to the root.
// The pace is set by the key memory: each level needs a registered read
// (parent, or both children on the two read ports) and then a compare and a
// write into the hole. Full pushes and empty pops go straight to the result.
// A new word is taken as soon as the previous result sits in the output
// register. No clearing pass after reset; words past the count go unused.
module binary_min_heap_priority_queue import bmh_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_action,
    input  logic signed [KEY_W-1:0] s_key_in,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [KEY_W-1:0] m_removed_key,
    output logic signed [KEY_W-1:0] m_min_key,
    output logic [CNT_W-1:0]        m_entry_count,
    output logic [1:0]              m_status
);

    bmh_cmd_t  cmd;
    bmh_stat_t stat;

    bmh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bmh_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .key_in      (s_key_in),
        .removed_key (m_removed_key),
        .min_key     (m_min_key),
        .entry_count (m_entry_count),
        .status      (m_status)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in flight");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |->
            m_entry_count == '0 && m_min_key == '0 && m_removed_key == '0)
        else $error("empty pop result not cleared");

    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |->
            m_entry_count == CNT_W'(CAPACITY) && m_removed_key == '0)
        else $error("full push result inconsistent");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= CNT_W'(CAPACITY) && m_status <= ST_EMPTY)
        else $error("result count or status out of range");

endmodule
